// ----- design/subpixel_jitter_sequence_generator_defines.svh -----
// Assertion macros for the subpixel jitter generator checkers.
`ifndef SUBPIXEL_JITTER_SEQUENCE_GENERATOR_DEFINES_SVH
`define SUBPIXEL_JITTER_SEQUENCE_GENERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SJSG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SJSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sjsg_pkg.sv -----
package sjsg_pkg;

	localparam int FRAME_W      = 64;
	localparam int OUT_W        = 17;
	localparam int PHASE_OUT_W  = 6;
	localparam int PERIOD_REG_W = 7;
	localparam int SCALE_W      = 17;
	localparam int HELD_W       = 6;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 17;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREEZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HELD   = 3'd5;

	localparam logic [PERIOD_REG_W-1:0] PERIOD_RESET = 7'd8;
	localparam logic [SCALE_W-1:0]      SCALE_ONE    = 17'h10000;
	localparam int                      SCALE_SHIFT  = 16;
	localparam int                      MIN_PERIOD   = 2;

	localparam int MOD_DIGIT_W = 2;

	localparam int               H2_BITS    = 7;
	localparam int               H3_DIGITS  = 4;
	localparam int               H3_REM_W   = 7;
	localparam logic [7:0]       H3_DENOM   = 8'd81;
	localparam int               DIV3_MUL   = 171;
	localparam int               DIV3_SHIFT = 9;

	localparam logic [31:0] R2_ALPHA_X = 32'd3242174889;
	localparam logic [31:0] R2_ALPHA_Y = 32'd2447445414;
	localparam logic [31:0] R2_HALF    = 32'h8000_0000;

	typedef struct packed {
		logic start;
		logic halton;
	} seq_req_t;

endpackage

// ----- design/sjsg_mod.sv -----
module sjsg_mod #(
	parameter int PER_W = 7,
	parameter int PH_W  = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sjsg_pkg::FRAME_W-1:0] dividend,
	input  logic [PER_W-1:0]           divisor,
	output logic                       done,
	output logic [PH_W-1:0]            remainder
);

	localparam int DIGITS = sjsg_pkg::FRAME_W / sjsg_pkg::MOD_DIGIT_W;
	localparam int CNT_W  = $clog2(DIGITS);
	localparam int W2     = PER_W + sjsg_pkg::MOD_DIGIT_W;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [sjsg_pkg::FRAME_W-1:0]  shreg_q;
	logic [PER_W-1:0]              rem_q;
	logic [PER_W-1:0]              div_q;

	logic [W2-1:0] rem4;
	logic [W2-1:0] d1;
	logic [W2-1:0] d2;
	logic [W2-1:0] d3;
	logic [W2-1:0] rem_nx;

	always_comb begin
		rem4 = {rem_q, shreg_q[sjsg_pkg::FRAME_W-1 -: sjsg_pkg::MOD_DIGIT_W]};
		d1 = W2'(div_q);
		d2 = d1 << 1;
		d3 = d2 + d1;
		if (rem4 >= d3) begin
			rem_nx = rem4 - d3;
		end else if (rem4 >= d2) begin
			rem_nx = rem4 - d2;
		end else if (rem4 >= d1) begin
			rem_nx = rem4 - d1;
		end else begin
			rem_nx = rem4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIGITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shreg_q <= shreg_q << sjsg_pkg::MOD_DIGIT_W;
			rem_q   <= PER_W'(rem_nx);
		end
	end

	assign done      = done_q;
	assign remainder = PH_W'(rem_q);

endmodule

// ----- design/sjsg_seq.sv -----
module sjsg_seq #(
	parameter int N_W       = 7,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sjsg_pkg::seq_req_t req,
	input  logic [N_W-1:0]     n,
	output logic               done,
	output logic [FRAC_BITS-1:0] hx,
	output logic [FRAC_BITS-1:0] hy
);

	localparam int STEPS_A = (FRAC_BITS > N_W) ? FRAC_BITS : N_W;
	localparam int STEPS   = (STEPS_A > sjsg_pkg::H3_DIGITS) ? STEPS_A : sjsg_pkg::H3_DIGITS;
	localparam int CNT_W   = $clog2(STEPS);
	localparam int EXT_W   = (N_W > sjsg_pkg::H2_BITS) ? N_W : sjsg_pkg::H2_BITS;
	localparam int PROD_W  = N_W + 8;
	localparam int RW      = sjsg_pkg::H3_REM_W;

	typedef enum logic [3:0] {
		SQ_IDLE  = 4'b0001,
		SQ_MUL   = 4'b0010,
		SQ_DIGIT = 4'b0100,
		SQ_DIV   = 4'b1000
	} sq_state_t;

	sq_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [N_W-1:0]     t_q;
	logic [RW-1:0]      rem_q;
	logic [31:0]        ax_q;
	logic [31:0]        ay_q;
	logic [FRAC_BITS-1:0] hx_q;
	logic [FRAC_BITS-1:0] hy_q;

	logic [EXT_W-1:0]              n_ext;
	logic [sjsg_pkg::H2_BITS-1:0]  rev;
	logic [FRAC_BITS-1:0]          h2;
	logic [PROD_W-1:0]             prod;
	logic [N_W-1:0]                q3;
	logic [N_W-1:0]                dig_full;
	logic [RW-1:0]                 r3_nx;
	logic [RW:0]                   rem2;
	logic                          qbit;
	logic [RW-1:0]                 rem_div;
	logic [31:0]                   ax_nx;
	logic [31:0]                   ay_nx;
	logic [31:0]                   fx;
	logic [31:0]                   fy;

	always_comb begin
		n_ext = EXT_W'(n);
		for (int i = 0; i < sjsg_pkg::H2_BITS; i++) begin
			rev[i] = n_ext[sjsg_pkg::H2_BITS-1-i];
		end
		h2 = FRAC_BITS'(rev) << (FRAC_BITS - sjsg_pkg::H2_BITS);

		prod     = PROD_W'(t_q) * PROD_W'(sjsg_pkg::DIV3_MUL);
		q3       = N_W'(prod >> sjsg_pkg::DIV3_SHIFT);
		dig_full = t_q - q3 - (q3 << 1);
		r3_nx    = (rem_q << 1) + rem_q + RW'(dig_full[1:0]);

		rem2    = {rem_q, 1'b0};
		qbit    = (rem2 >= sjsg_pkg::H3_DENOM);
		rem_div = qbit ? RW'(rem2 - sjsg_pkg::H3_DENOM) : RW'(rem2);

		ax_nx = (ax_q << 1) + (t_q[N_W-1] ? sjsg_pkg::R2_ALPHA_X : 32'd0);
		ay_nx = (ay_q << 1) + (t_q[N_W-1] ? sjsg_pkg::R2_ALPHA_Y : 32'd0);
		fx    = ax_nx + sjsg_pkg::R2_HALF;
		fy    = ay_nx + sjsg_pkg::R2_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					if (req.start) begin
						if (req.halton) begin
							state_q <= SQ_DIGIT;
							cnt_q   <= CNT_W'(sjsg_pkg::H3_DIGITS - 1);
						end else begin
							state_q <= SQ_MUL;
							cnt_q   <= CNT_W'(N_W - 1);
						end
					end
				end
				SQ_DIGIT: begin
					if (cnt_q == '0) begin
						state_q <= SQ_DIV;
						cnt_q   <= CNT_W'(FRAC_BITS - 1);
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				SQ_DIV, SQ_MUL: begin
					if (cnt_q == '0) begin
						state_q <= SQ_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (req.start) begin
					t_q   <= n;
					rem_q <= '0;
					ax_q  <= '0;
					ay_q  <= '0;
					if (req.halton) begin
						hx_q <= h2;
					end
				end
			end
			SQ_DIGIT: begin
				t_q   <= q3;
				rem_q <= r3_nx;
			end
			SQ_DIV: begin
				rem_q <= rem_div;
				hy_q  <= {hy_q[FRAC_BITS-2:0], qbit};
			end
			SQ_MUL: begin
				t_q  <= t_q << 1;
				ax_q <= ax_nx;
				ay_q <= ay_nx;
				if (cnt_q == '0) begin
					hx_q <= fx[31 -: FRAC_BITS];
					hy_q <= fy[31 -: FRAC_BITS];
				end
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	assign done = done_q;
	assign hx   = hx_q;
	assign hy   = hy_q;

endmodule

// ----- design/sjsg_scale.sv -----
module sjsg_scale #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [FRAC_BITS-1:0]               h,
	input  logic [sjsg_pkg::SCALE_W-1:0]       scale,
	output logic                               done,
	output logic signed [sjsg_pkg::OUT_W-1:0]  result
);

	localparam int V_W   = FRAC_BITS + 1;
	localparam int P_W   = FRAC_BITS + sjsg_pkg::SCALE_W + 1;
	localparam int S_W   = FRAC_BITS + 2;
	localparam int EXT_W = (S_W > sjsg_pkg::OUT_W) ? S_W : sjsg_pkg::OUT_W;
	localparam int CNT_W = $clog2(sjsg_pkg::SCALE_W);

	localparam logic signed [V_W-1:0] HALF_V     = V_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [S_W-1:0] HALF_S     = S_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [S_W-1:0] NEG_HALF_S = -HALF_S;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [V_W-1:0]         v_q;
	logic [sjsg_pkg::SCALE_W-1:0]  sc_q;
	logic signed [P_W-1:0]         acc_q;

	logic signed [V_W-1:0]   v_in;
	logic signed [P_W-1:0]   addend;
	logic signed [P_W-1:0]   acc_nx;
	logic signed [P_W-1:0]   s_full;
	logic signed [S_W-1:0]   s;
	logic signed [S_W-1:0]   s_cl;
	logic signed [EXT_W-1:0] s_ext;

	always_comb begin
		v_in   = $signed({1'b0, h}) - HALF_V;
		addend = sc_q[sjsg_pkg::SCALE_W-1] ? P_W'(v_q) : {P_W{1'b0}};
		acc_nx = (acc_q <<< 1) + addend;
		s_full = acc_q >>> sjsg_pkg::SCALE_SHIFT;
		s      = S_W'(s_full);
		if (s > HALF_S) begin
			s_cl = HALF_S;
		end else if (s < NEG_HALF_S) begin
			s_cl = NEG_HALF_S;
		end else begin
			s_cl = s;
		end
		s_ext = EXT_W'(s_cl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(sjsg_pkg::SCALE_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v_in;
			sc_q  <= scale;
			acc_q <= '0;
		end else if (busy_q) begin
			sc_q  <= sc_q << 1;
			acc_q <= acc_nx;
		end
	end

	assign done   = done_q;
	assign result = s_ext[sjsg_pkg::OUT_W-1:0];

endmodule

// ----- design/subpixel_jitter_sequence_generator.sv -----
// Subpixel jitter generator: one frame number in, one jitter pair out.
// Input transfer: frame_valid high and frame_stall low at a rising edge of clk.
// Output transfer: jitter_valid high and jitter_stall low; offset_x and
// offset_y are two's complement in 1/2^FRAC_BITS pixel, phase_used is the
// sequence phase. Registers are written over cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and writes belong between items.
// Flow: the frame phase comes from a radix-4 serial remainder over the 64-bit
// frame number (skipped when the phase is held), then the sequence unit (N bit
// steps for R2 with N = clog2(MAX_PERIOD+1), or 4 ternary digit steps plus
// FRAC_BITS quotient bits for Halton), then the serial scale multiply over the
// 17 scale bits, then the output register. When frozen or at zero scale, the
// item skips the remainder, sequence and scale units. One item is in work at
// a time; the next is taken as soon as the previous one has reached the output
// register. A stalled result holds in the output register; a finished item
// waits for it. Reset clears the handshakes, returns the unit to idle and loads
// register defaults: period 8, R2 sequence, full scale, freeze and hold off,
// held 0.
module subpixel_jitter_sequence_generator #(
	parameter int MAX_PERIOD = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   frame_valid,
	output logic                                   frame_stall,
	input  logic [sjsg_pkg::FRAME_W-1:0]           frame_number,
	output logic                                   jitter_valid,
	input  logic                                   jitter_stall,
	output logic signed [sjsg_pkg::OUT_W-1:0]      offset_x,
	output logic signed [sjsg_pkg::OUT_W-1:0]      offset_y,
	output logic [sjsg_pkg::PHASE_OUT_W-1:0]       phase_used,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sjsg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sjsg_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int PER_W = $clog2(MAX_PERIOD + 1);
	localparam int PH_W  = $clog2(MAX_PERIOD);
	localparam int CMP_W = (PER_W > sjsg_pkg::PERIOD_REG_W) ? PER_W : sjsg_pkg::PERIOD_REG_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MOD   = 5'b00010,
		ST_SEQ   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	logic [sjsg_pkg::PERIOD_REG_W-1:0] period_q;
	logic                              seq_sel_q;
	logic [sjsg_pkg::SCALE_W-1:0]      scale_q;
	logic                              freeze_q;
	logic                              hold_q;
	logic [sjsg_pkg::HELD_W-1:0]       held_q;

	state_t                               state_q;
	state_t                               state_nx;
	logic                                 zero_q;
	logic [PH_W-1:0]                      phase_q;
	logic                                 out_valid_q;
	logic signed [sjsg_pkg::OUT_W-1:0]    offset_x_q;
	logic signed [sjsg_pkg::OUT_W-1:0]    offset_y_q;
	logic [sjsg_pkg::PHASE_OUT_W-1:0]     phase_out_q;

	logic [CMP_W-1:0]              per_raw;
	logic [CMP_W-1:0]              per_cl;
	logic [PER_W-1:0]              period_eff;
	logic [CMP_W-1:0]              held_ext;
	logic [CMP_W-1:0]              per_m1;
	logic [PH_W-1:0]               hold_phase;
	logic [sjsg_pkg::SCALE_W-1:0]  scale_eff;
	logic                          zero_now;
	logic [PH_W-1:0]               phase_sel;
	logic [PER_W-1:0]              n_in;
	logic [CMP_W-1:0]              phase_ext;
	logic                          out_free;
	logic                          load;

	logic                          mod_start;
	logic                          mod_done;
	logic [PH_W-1:0]               mod_rem;
	sjsg_pkg::seq_req_t            seq_req;
	logic                          seq_done;
	logic [FRAC_BITS-1:0]          hx;
	logic [FRAC_BITS-1:0]          hy;
	logic                          scl_start;
	logic                          scl_done_x;
	logic                          scl_done_y;
	logic signed [sjsg_pkg::OUT_W-1:0] res_x;
	logic signed [sjsg_pkg::OUT_W-1:0] res_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= sjsg_pkg::PERIOD_RESET;
			seq_sel_q <= 1'b0;
			scale_q   <= sjsg_pkg::SCALE_ONE;
			freeze_q  <= 1'b0;
			hold_q    <= 1'b0;
			held_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sjsg_pkg::REG_PERIOD: period_q  <= cfg_data[sjsg_pkg::PERIOD_REG_W-1:0];
				sjsg_pkg::REG_SEQ:    seq_sel_q <= cfg_data[0];
				sjsg_pkg::REG_SCALE:  scale_q   <= cfg_data[sjsg_pkg::SCALE_W-1:0];
				sjsg_pkg::REG_FREEZE: freeze_q  <= cfg_data[0];
				sjsg_pkg::REG_HOLD:   hold_q    <= cfg_data[0];
				sjsg_pkg::REG_HELD:   held_q    <= cfg_data[sjsg_pkg::HELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		per_raw = CMP_W'(period_q);
		if (per_raw < CMP_W'(sjsg_pkg::MIN_PERIOD)) begin
			per_cl = CMP_W'(sjsg_pkg::MIN_PERIOD);
		end else if (per_raw > CMP_W'(MAX_PERIOD)) begin
			per_cl = CMP_W'(MAX_PERIOD);
		end else begin
			per_cl = per_raw;
		end
		period_eff = PER_W'(per_cl);
		held_ext   = CMP_W'(held_q);
		per_m1     = per_cl - CMP_W'(1);
		hold_phase = PH_W'((held_ext < per_m1) ? held_ext : per_m1);
		scale_eff  = (scale_q > sjsg_pkg::SCALE_ONE) ? sjsg_pkg::SCALE_ONE : scale_q;
		zero_now   = freeze_q || (scale_eff == '0);
		phase_sel  = (state_q == ST_IDLE) ? hold_phase : mod_rem;
		n_in       = PER_W'(phase_sel) + PER_W'(1);
		phase_ext  = CMP_W'(phase_q);
		out_free   = !out_valid_q || !jitter_stall;
	end

	always_comb begin
		state_nx       = state_q;
		mod_start      = 1'b0;
		seq_req.start  = 1'b0;
		seq_req.halton = seq_sel_q;
		scl_start      = 1'b0;
		load           = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (frame_valid) begin
					if (zero_now) begin
						state_nx = ST_DONE;
					end else if (hold_q) begin
						seq_req.start = 1'b1;
						state_nx      = ST_SEQ;
					end else begin
						mod_start = 1'b1;
						state_nx  = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					seq_req.start = 1'b1;
					state_nx      = ST_SEQ;
				end
			end
			ST_SEQ: begin
				if (seq_done) begin
					scl_start = 1'b1;
					state_nx  = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scl_done_x && scl_done_y) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && frame_valid) begin
				zero_q <= zero_now;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!jitter_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_req.start) begin
			phase_q <= phase_sel;
		end
		if (load) begin
			offset_x_q  <= zero_q ? '0 : res_x;
			offset_y_q  <= zero_q ? '0 : res_y;
			phase_out_q <= zero_q ? '0 : phase_ext[sjsg_pkg::PHASE_OUT_W-1:0];
		end
	end

	sjsg_mod #(
		.PER_W (PER_W),
		.PH_W  (PH_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (frame_number),
		.divisor   (period_eff),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	sjsg_seq #(
		.N_W       (PER_W),
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seq_req),
		.n      (n_in),
		.done   (seq_done),
		.hx     (hx),
		.hy     (hy)
	);

	sjsg_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scl_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.h      (hx),
		.scale  (scale_eff),
		.done   (scl_done_x),
		.result (res_x)
	);

	sjsg_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scl_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.h      (hy),
		.scale  (scale_eff),
		.done   (scl_done_y),
		.result (res_y)
	);

	assign frame_stall  = (state_q != ST_IDLE);
	assign jitter_valid = out_valid_q;
	assign offset_x     = offset_x_q;
	assign offset_y     = offset_y_q;
	assign phase_used   = phase_out_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- design/sjsg_chk.sv -----
`include "subpixel_jitter_sequence_generator_defines.svh"

module sjsg_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                frame_valid,
	input logic                                frame_stall,
	input logic                                jitter_valid,
	input logic                                jitter_stall,
	input logic signed [sjsg_pkg::OUT_W-1:0]   offset_x,
	input logic signed [sjsg_pkg::OUT_W-1:0]   offset_y,
	input logic [sjsg_pkg::PHASE_OUT_W-1:0]    phase_used
);

	`SJSG_ASSERT_NEXT(a_out_hold, jitter_valid && jitter_stall, jitter_valid && $stable(offset_x) && $stable(offset_y) && $stable(phase_used), "stalled result changed or dropped")
	`SJSG_ASSERT_NEXT(a_busy_after_take, frame_valid && !frame_stall, frame_stall, "frame taken but block not busy")
	`SJSG_ASSERT_NEXT(a_no_instant_result, frame_valid && !frame_stall && !jitter_valid, !jitter_valid, "result shown in the cycle after the transfer")
	`SJSG_ASSERT_IMP(a_result_from_work, $rose(jitter_valid), $past(frame_stall), "result appeared while block was idle")

endmodule

bind subpixel_jitter_sequence_generator sjsg_chk u_sjsg_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame_valid),
	.frame_stall  (frame_stall),
	.jitter_valid (jitter_valid),
	.jitter_stall (jitter_stall),
	.offset_x     (offset_x),
	.offset_y     (offset_y),
	.phase_used   (phase_used)
);
